### hdl/mrp_pkg.sv
`default_nettype none

package mrp_pkg;

  typedef enum logic [2:0] {
    PH_ADDR,
    PH_FUNC,
    PH_COUNT,
    PH_DATA,
    PH_CRCLO,
    PH_CRCHI
  } phase_t;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  DATA_BYTE_COUNT   = 8'h04;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_xfer_t;

endpackage

`default_nettype wire

### hdl/mrp_crc_byte.sv
`default_nettype none

module mrp_crc_byte (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);

  // reflected crc16, one byte per cycle as eight unrolled bit steps
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mrp_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

### hdl/mrp_frame_fsm.sv
`default_nettype none

module mrp_frame_fsm #(
  parameter int NUM_SENSORS = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mrp_pkg::rx_xfer_t rx,
  output logic                  rx_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_frame_status,
  output logic [2:0]            out_sensor_index,
  output logic signed [31:0]    out_raw_force
);

  mrp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  slave_r, slave_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crclo_r;
  logic [7:0]  payload_r [4];
  logic [15:0] crc_new;
  logic        addr_ok;
  logic        emit;
  logic        fire;
  logic        crc_ok;
  logic        out_valid_r;
  logic        status_r;
  logic [2:0]  index_r;
  logic [31:0] force_r;

  mrp_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (rx.data),
    .crc_out (crc_new)
  );

  assign addr_ok  = (rx.data != 8'h00) && (rx.data <= 8'(NUM_SENSORS));
  // a result can only leave the last crc byte when the output slot frees up
  assign rx_ready = (phase_r != mrp_pkg::PH_CRCHI) || !out_valid_r || out_ready;
  assign fire     = rx.valid && rx_ready;
  assign crc_ok   = ({rx.data, crclo_r} == crc_r);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      mrp_pkg::PH_ADDR:  if (addr_ok) phase_nxt = mrp_pkg::PH_FUNC;
      mrp_pkg::PH_FUNC:  phase_nxt = (rx.data == mrp_pkg::FUNC_READ_HOLDING) ?
                                     mrp_pkg::PH_COUNT : mrp_pkg::PH_ADDR;
      mrp_pkg::PH_COUNT: phase_nxt = (rx.data == mrp_pkg::DATA_BYTE_COUNT) ?
                                     mrp_pkg::PH_DATA : mrp_pkg::PH_ADDR;
      mrp_pkg::PH_DATA:  if (pos_r == 2'd3) phase_nxt = mrp_pkg::PH_CRCLO;
      mrp_pkg::PH_CRCLO: phase_nxt = mrp_pkg::PH_CRCHI;
      default:           phase_nxt = mrp_pkg::PH_ADDR;
    endcase
  end

  always_comb begin
    slave_nxt = slave_r;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    emit      = 1'b0;
    unique case (phase_r)
      mrp_pkg::PH_ADDR: begin
        if (addr_ok) begin
          slave_nxt = rx.data;
          pos_nxt   = 2'd0;
          crc_nxt   = crc_new;
        end
      end
      mrp_pkg::PH_FUNC: begin
        if (rx.data == mrp_pkg::FUNC_READ_HOLDING) begin
          crc_nxt = crc_new;
        end else begin
          slave_nxt = 8'h00;
          pos_nxt   = 2'd0;
          crc_nxt   = mrp_pkg::CRC_INIT;
        end
      end
      mrp_pkg::PH_COUNT: begin
        pos_nxt = 2'd0;
        if (rx.data == mrp_pkg::DATA_BYTE_COUNT) begin
          crc_nxt = crc_new;
        end else begin
          slave_nxt = 8'h00;
          crc_nxt   = mrp_pkg::CRC_INIT;
        end
      end
      mrp_pkg::PH_DATA: begin
        crc_nxt = crc_new;
        pos_nxt = pos_r + 2'd1;
      end
      mrp_pkg::PH_CRCLO: begin
      end
      mrp_pkg::PH_CRCHI: begin
        emit      = 1'b1;
        slave_nxt = 8'h00;
        pos_nxt   = 2'd0;
        crc_nxt   = mrp_pkg::CRC_INIT;
      end
      default: begin
        slave_nxt = 8'h00;
        pos_nxt   = 2'd0;
        crc_nxt   = mrp_pkg::CRC_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mrp_pkg::PH_ADDR;
      slave_r     <= 8'h00;
      pos_r       <= 2'd0;
      crc_r       <= mrp_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        slave_r <= slave_nxt;
        pos_r   <= pos_nxt;
        crc_r   <= crc_nxt;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (phase_r == mrp_pkg::PH_DATA)) begin
      payload_r[pos_r] <= rx.data;
    end
    if (fire && (phase_r == mrp_pkg::PH_CRCLO)) begin
      crclo_r <= rx.data;
    end
    if (fire && emit) begin
      status_r <= !crc_ok;
      index_r  <= 3'(slave_r - 8'd1);
      force_r  <= crc_ok ? {payload_r[2], payload_r[3], payload_r[0], payload_r[1]} : 32'h0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = status_r;
  assign out_sensor_index = index_r;
  assign out_raw_force    = signed'(force_r);

endmodule

`default_nettype wire

### hdl/modbus_read_response_parser.sv
// modbus rtu read-holding-registers reply parser
//
// in channel: one received byte per transaction (in_valid / in_ready).
// out channel: one result per good or bad-crc frame (out_valid / out_ready):
//   status (0 ok, 1 crc mismatch with raw_force forced to 0), sensor index
//   (address minus one) and the signed 32-bit value.
// throughput: one byte per cycle while in_ready is high; the crc advances a
// whole byte per cycle through an unrolled eight-step update between the
// input register and the frame state registers.
// output: the result is valid on the cycle after the final crc byte leaves
// the input register.
// reset: parser waits for an address byte, crc at all ones, no result held.
// stall: a waiting result holds the output register; bytes keep flowing
// until the final crc byte of the next frame, which waits in the input
// register with in_ready low until the result slot frees.
`default_nettype none

module modbus_read_response_parser #(
  parameter int NUM_SENSORS = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_frame_status,
  output logic [2:0]             out_sensor_index,
  output logic signed [31:0]     out_raw_force
);

  logic              s1_valid_r;
  logic [7:0]        s1_data_r;
  logic              rx_ready;
  mrp_pkg::rx_xfer_t rx;

  assign in_ready = !s1_valid_r || rx_ready;
  assign rx.valid = s1_valid_r;
  assign rx.data  = s1_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (rx_ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_rx_byte;
    end
  end

  mrp_frame_fsm #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_fsm (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx               (rx),
    .rx_ready         (rx_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_sensor_index (out_sensor_index),
    .out_raw_force    (out_raw_force)
  );

  a_bad_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_status) |-> (out_raw_force == 32'sd0))
    else $error("crc mismatch result carries a nonzero value");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((NUM_SENSORS > 8) || (int'(out_sensor_index) < NUM_SENSORS)))
    else $error("sensor index outside the configured range");

endmodule

`default_nettype wire
